// ===== hdl/aef_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio envelope framer package
// Shared codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package aef_pkg;

    // Action codes carried in the input tuser.
    localparam logic [1:0] ACT_BEGIN  = 2'd0;
    localparam logic [1:0] ACT_PACKET = 2'd1;
    localparam logic [1:0] ACT_BYTE   = 2'd2;
    localparam logic [1:0] ACT_FINISH = 2'd3;

    // Result status codes carried in the output tuser.
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_INVALID   = 3'd1;
    localparam logic [2:0] STAT_NONCONTIG = 3'd2;
    localparam logic [2:0] STAT_TOO_LARGE = 3'd3;
    localparam logic [2:0] STAT_TOO_SMALL = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FORMAT_MODE = 3'd0;
    localparam logic [2:0] CFG_SESSION     = 3'd1;
    localparam logic [2:0] CFG_CAPACITY    = 3'd2;
    localparam logic [2:0] CFG_VER_ONE     = 3'd3;
    localparam logic [2:0] CFG_VER_TWO     = 3'd4;
    localparam logic [2:0] CFG_AUDIO_TYPE  = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 3;

    localparam int HDR_LEN     = 16;
    localparam int WORD_LIMIT  = 512;
    // Word counter width: an envelope never exceeds 64 words.
    localparam int WCNT_W      = 7;
    localparam int PTOTAL_W    = 17;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_EMIT,
        SQ_ERROR
    } t_seq_state;

endpackage

// ===== hdl/audio_envelope_framer.sv =====
// ----------------------------------------------------------------------------
// Audio envelope framer
// Collects packet descriptors and payload bytes and emits a framed envelope.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel; tuser selects begin, packet descriptor,
// payload byte or finish. Begin, descriptor and byte items are taken at once
// while idle, so payload can stream in at one byte per cycle. Payload bytes are
// gathered into 64-bit words and written to a word-wide RAM as each word
// fills; the partial tail word stays in a register.
// A finish transfer starts the drain: the block emits the 16-byte header as
// two words and then the payload, one word per cycle while m_axis_tready is
// high, or a single error result. The first word appears in the cycle after the
// finish transfer; an envelope of N bytes, header included, is (N + 7) / 8 words.
// The RAM read port is addressed one word ahead, so a stall on m_axis simply
// holds the address and the output word. s_axis_tready is low from the finish
// transfer until the last result is taken.
// The configuration channel is always ready; writes are expected only while
// no envelope is being drained. Reset restores the register defaults and
// clears the envelope state; the payload RAM needs no clearing because only
// words that were written are ever read.
// ----------------------------------------------------------------------------
module audio_envelope_framer #(
    parameter int PAYLOAD_BYTES = 496
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aef_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [aef_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: sequence_req[31:0], flag_bits[39:32], packet_length[55:40],
    //        data_byte[63:56]
    input  logic [aef_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: action[1:0]
    input  logic [aef_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: word[63:0], byte_count[67:64], total_length[77:68], zero[79:78]
    output logic [aef_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // tuser: status[2:0]
    output logic [aef_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast
);

    import aef_pkg::*;

    localparam int WORDS   = (PAYLOAD_BYTES + 7) / 8;
    localparam int AW      = $clog2(WORDS);
    localparam int WPW     = $clog2(PAYLOAD_BYTES + 1);
    localparam int LIMIT_C = (HDR_LEN + PAYLOAD_BYTES < WORD_LIMIT) ?
                             (HDR_LEN + PAYLOAD_BYTES) : WORD_LIMIT;

    // Configuration registers.
    logic        r_format_mode;
    logic [31:0] r_session;
    logic [9:0]  r_capacity;
    logic [7:0]  r_ver_one;
    logic [7:0]  r_ver_two;
    logic [7:0]  r_audio_type;

    // Envelope state.
    logic [WPW-1:0]      r_wp, n_wp;
    logic [8:0]          r_pkts, n_pkts;
    logic [31:0]         r_start_seq, n_start_seq;
    logic [31:0]         r_exp_seq, n_exp_seq;
    logic [7:0]          r_flags, n_flags;
    logic [PTOTAL_W-1:0] r_ptotal, n_ptotal;
    logic [15:0]         r_left, n_left;
    logic [2:0]          r_ferr, n_ferr;
    logic [63:0]         r_acc, n_acc;

    // Drain sequencer.
    t_seq_state          r_state, n_state;
    logic [WCNT_W-1:0]   r_k, n_k;
    logic [WCNT_W-1:0]   r_nwords, n_nwords;
    logic [2:0]          r_status, n_status;

    // Input fields.
    logic [1:0]  in_action;
    logic [31:0] in_seq;
    logic [7:0]  in_flags;
    logic [15:0] in_len;
    logic [7:0]  in_data;

    logic        in_fire;
    logic        out_fire;
    logic        store_en;
    logic [7:0]  store_byte;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0] ram_q;
    logic [WCNT_W-1:0] k_sel;

    logic [2:0]  desc_err;
    logic [8:0]  pkts_inc;
    logic [PTOTAL_W:0] ptotal_sum;
    logic [9:0]  limit;
    logic [PTOTAL_W:0] total_full;
    logic [2:0]  fin_status;
    logic [10:0] total_round;

    logic [63:0] hdr_word0;
    logic [63:0] hdr_word1;
    logic [WCNT_W-1:0] pay_idx;
    logic [63:0] emit_word;
    logic [3:0]  emit_count;
    logic [9:0]  emit_total;
    logic        emit_last;

    assign in_seq    = s_axis_tdata[31:0];
    assign in_flags  = s_axis_tdata[39:32];
    assign in_len    = s_axis_tdata[55:40];
    assign in_data   = s_axis_tdata[63:56];
    assign in_action = s_axis_tuser;

    assign s_axis_tready = (r_state == SQ_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= 1'b1;
            r_session     <= '0;
            r_capacity    <= 10'd512;
            r_ver_one     <= 8'd1;
            r_ver_two     <= 8'd2;
            r_audio_type  <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FORMAT_MODE: r_format_mode <= i_cfg_data[0];
                CFG_SESSION:     r_session     <= i_cfg_data;
                CFG_CAPACITY:    r_capacity    <= i_cfg_data[9:0];
                CFG_VER_ONE:     r_ver_one     <= i_cfg_data[7:0];
                CFG_VER_TWO:     r_ver_two     <= i_cfg_data[7:0];
                CFG_AUDIO_TYPE:  r_audio_type  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Descriptor checks and finish status
    // ------------------------------------------------------------------
    always_comb begin
        if (r_left != 16'd0) begin
            desc_err = STAT_INVALID;
        end else if (r_pkts >= 9'd255) begin
            desc_err = STAT_INVALID;
        end else if (in_seq != r_exp_seq) begin
            desc_err = STAT_NONCONTIG;
        end else if (r_format_mode && (in_len > 16'd255)) begin
            desc_err = STAT_TOO_LARGE;
        end else begin
            desc_err = STAT_OK;
        end
    end

    assign pkts_inc   = (r_pkts < 9'd256) ? (r_pkts + 9'd1) : r_pkts;
    assign ptotal_sum = (PTOTAL_W+1)'(r_ptotal) + (PTOTAL_W+1)'(in_len)
                      + (PTOTAL_W+1)'(r_format_mode);

    assign limit      = (r_capacity < 10'(LIMIT_C)) ? r_capacity : 10'(LIMIT_C);
    assign total_full = (PTOTAL_W+1)'(r_ptotal) + (PTOTAL_W+1)'(HDR_LEN);

    always_comb begin
        if (r_capacity < 10'(HDR_LEN)) begin
            fin_status = STAT_INVALID;
        end else if (!r_format_mode && (r_pkts != 9'd1)) begin
            fin_status = STAT_INVALID;
        end else if (r_ferr != STAT_OK) begin
            fin_status = r_ferr;
        end else if (r_left != 16'd0) begin
            fin_status = STAT_INVALID;
        end else if ((r_ptotal > PTOTAL_W'(16'hffff)) ||
                     (total_full > (PTOTAL_W+1)'(limit))) begin
            fin_status = STAT_TOO_SMALL;
        end else begin
            fin_status = STAT_OK;
        end
    end

    // Only used when the status is ok, so the total fits in ten bits.
    assign total_round = 11'(total_full[9:0]) + 11'd7;

    // ------------------------------------------------------------------
    // Payload store path
    // ------------------------------------------------------------------
    always_comb begin
        store_byte = (in_action == ACT_PACKET) ? in_len[7:0] : in_data;
        store_en   = 1'b0;
        if (in_fire && (r_wp < WPW'(PAYLOAD_BYTES))) begin
            if (in_action == ACT_PACKET) begin
                store_en = r_format_mode;
            end else if (in_action == ACT_BYTE) begin
                store_en = (r_left != 16'd0);
            end
        end
    end

    // A word goes to RAM when its eighth byte arrives.
    assign ram_we    = store_en && (r_wp[2:0] == 3'd7);
    assign ram_waddr = AW'(r_wp >> 3);
    assign ram_wdata = {store_byte, r_acc[55:0]};

    // Read one word ahead while the output advances, else hold the address.
    assign k_sel     = ((r_state == SQ_EMIT) && out_fire) ? (r_k + WCNT_W'(1)) : r_k;
    assign ram_raddr = AW'(k_sel - WCNT_W'(2));

    aef_ram #(
        .WIDTH (64),
        .DEPTH (WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_wp        = r_wp;
        n_pkts      = r_pkts;
        n_start_seq = r_start_seq;
        n_exp_seq   = r_exp_seq;
        n_flags     = r_flags;
        n_ptotal    = r_ptotal;
        n_left      = r_left;
        n_ferr      = r_ferr;
        n_acc       = r_acc;
        n_state     = r_state;
        n_k         = r_k;
        n_nwords    = r_nwords;
        n_status    = r_status;

        if (store_en) begin
            n_wp = r_wp + WPW'(1);
            if (r_wp[2:0] == 3'd7) begin
                n_acc = '0;
            end else begin
                n_acc[8*r_wp[2:0] +: 8] = store_byte;
            end
        end

        case (r_state)
            SQ_IDLE: begin
                if (in_fire) begin
                    case (in_action)
                        ACT_BEGIN: begin
                            n_wp        = '0;
                            n_pkts      = '0;
                            n_start_seq = in_seq;
                            n_exp_seq   = in_seq;
                            n_flags     = in_flags;
                            n_ptotal    = '0;
                            n_left      = '0;
                            n_ferr      = STAT_OK;
                            n_acc       = '0;
                        end
                        ACT_PACKET: begin
                            if (r_ferr == STAT_OK) begin
                                n_ferr = desc_err;
                            end
                            n_flags  = r_flags | in_flags;
                            n_ptotal = ptotal_sum[PTOTAL_W] ? '1 : ptotal_sum[PTOTAL_W-1:0];
                            n_left   = in_len;
                            n_pkts   = pkts_inc;
                            n_exp_seq = r_start_seq + 32'(pkts_inc);
                        end
                        ACT_BYTE: begin
                            if (r_left != 16'd0) begin
                                n_left = r_left - 16'd1;
                            end
                        end
                        ACT_FINISH: begin
                            n_status = fin_status;
                            n_k      = '0;
                            n_nwords = WCNT_W'(total_round >> 3);
                            n_state  = (fin_status == STAT_OK) ? SQ_EMIT : SQ_ERROR;
                        end
                        default: ;
                    endcase
                end
            end
            SQ_EMIT: begin
                if (out_fire) begin
                    n_k = r_k + WCNT_W'(1);
                    if (emit_last) begin
                        n_state = SQ_IDLE;
                    end
                end
            end
            SQ_ERROR: begin
                if (out_fire) begin
                    n_state = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_pkts      <= '0;
            r_start_seq <= '0;
            r_exp_seq   <= '0;
            r_flags     <= '0;
            r_ptotal    <= '0;
            r_left      <= '0;
            r_ferr      <= STAT_OK;
            r_acc       <= '0;
            r_state     <= SQ_IDLE;
            r_k         <= '0;
            r_nwords    <= '0;
            r_status    <= STAT_OK;
        end else begin
            r_wp        <= n_wp;
            r_pkts      <= n_pkts;
            r_start_seq <= n_start_seq;
            r_exp_seq   <= n_exp_seq;
            r_flags     <= n_flags;
            r_ptotal    <= n_ptotal;
            r_left      <= n_left;
            r_ferr      <= n_ferr;
            r_acc       <= n_acc;
            r_state     <= n_state;
            r_k         <= n_k;
            r_nwords    <= n_nwords;
            r_status    <= n_status;
        end
    end

    // ------------------------------------------------------------------
    // Output word assembly
    // ------------------------------------------------------------------
    assign hdr_word0 = {r_session, 8'h00, 8'(HDR_LEN),
                        r_audio_type, (r_format_mode ? r_ver_two : r_ver_one)};
    assign hdr_word1 = {r_ptotal[15:8], r_ptotal[7:0],
                        (r_format_mode ? r_pkts[7:0] : 8'h00),
                        r_flags, r_start_seq};

    assign pay_idx    = r_k - WCNT_W'(2);
    assign emit_last  = (r_k == (r_nwords - WCNT_W'(1)));
    assign emit_total = total_full[9:0];

    always_comb begin
        if (r_k == WCNT_W'(0)) begin
            emit_word = hdr_word0;
        end else if (r_k == WCNT_W'(1)) begin
            emit_word = hdr_word1;
        end else if (PTOTAL_W'(pay_idx) < PTOTAL_W'(r_wp >> 3)) begin
            emit_word = ram_q;
        end else begin
            // The tail word still sits in the gather register.
            emit_word = r_acc;
        end

        if (emit_last && (emit_total[2:0] != 3'd0)) begin
            emit_count = {1'b0, emit_total[2:0]};
        end else begin
            emit_count = 4'd8;
        end
    end

    always_comb begin
        m_axis_tvalid = 1'b0;
        m_axis_tdata  = '0;
        m_axis_tuser  = STAT_OK;
        m_axis_tlast  = 1'b0;
        case (r_state)
            SQ_EMIT: begin
                m_axis_tvalid = 1'b1;
                m_axis_tdata  = {2'b00, emit_total, emit_count, emit_word};
                m_axis_tlast  = emit_last;
            end
            SQ_ERROR: begin
                m_axis_tvalid = 1'b1;
                m_axis_tuser  = r_status;
                m_axis_tlast  = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/aef_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module aef_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 62
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/aef_checker.sv =====
// ----------------------------------------------------------------------------
// Audio envelope framer checker
// Port-level assertions on the framer, attached by a bind statement.
// ----------------------------------------------------------------------------
module aef_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [aef_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [aef_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                            m_axis_tlast
);

    import aef_pkg::*;

    logic out_ok_mid;
    assign out_ok_mid = m_axis_tvalid && m_axis_tready && !m_axis_tlast
                        && (m_axis_tuser == STAT_OK);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // No input is taken while an envelope is being emitted.
    a_no_input_during_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while results are pending");

    // An error result is a single, empty, final transfer.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_OK) |->
            m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed error result");

    // Every word but the last of an envelope is full.
    a_full_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_OK) && !m_axis_tlast |->
            (m_axis_tdata[67:64] == 4'd8))
        else $error("short word before end of envelope");

    // Within one envelope the total length does not change between words.
    a_total_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ok_mid |=> !m_axis_tvalid || ($stable(m_axis_tdata[77:68])))
        else $error("total length changed within an envelope");

endmodule

bind audio_envelope_framer aef_checker u_aef_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
